/* hdl/tpa_pkg.sv */
// Shared types and constants for the palette analyzer.
package tpa_pkg;

    localparam int COLOR_W = 32;
    localparam int CNT_W   = 17;
    localparam int USED_W  = 9;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_LOOK = 2'd2;

    localparam logic [1:0] CLS_FULL    = 2'd0;
    localparam logic [1:0] CLS_SOLID   = 2'd1;
    localparam logic [1:0] CLS_MONO    = 2'd2;
    localparam logic [1:0] CLS_INDEXED = 2'd3;

    localparam logic REG_MAX_COLORS = 1'b0;

    typedef enum logic [1:0] {
        PH_SOLID   = 2'd0,
        PH_MONO    = 2'd1,
        PH_INDEXED = 2'd2,
        PH_ABORT   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        SRC_FIRST  = 2'd0,
        SRC_SECOND = 2'd1,
        SRC_RUN    = 2'd2,
        SRC_LOOK   = 2'd3
    } t_src;

    typedef struct packed {
        logic capture;
        logic push_upd;
        logic clr_used;
        logic ins_begin;
        t_src ins_src;
        logic srch_rd;
        logic k_inc;
        logic set_hit;
        logic look_hit;
        logic fail;
        logic new_slot;
        logic shift_rd;
        logic shift_move;
        logic put;
        logic seed_ok;
        logic run_ok;
        logic rd_sel;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       last;
        t_phase     phase;
        logic       need_ins;
        logic       k_end;
        logic       hit;
        logic       full;
        logic       j_zero;
        logic       shift_less;
        logic       sel_ok;
        logic       out_free;
    } t_status;

endpackage

/* hdl/tpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tpa_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/tpa_ctrl.sv */
// Sequencer for pixel pushes, palette insertion, entry reads and lookups.
module tpa_ctrl import tpa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_st,
    output t_cmd    o_cmd,
    output logic    o_in_stall
);

    typedef enum logic [11:0] {
        S_IDLE      = 12'b000000000001,
        S_EXEC      = 12'b000000000010,
        S_POST      = 12'b000000000100,
        S_SRCH_RD   = 12'b000000001000,
        S_SRCH_CHK  = 12'b000000010000,
        S_FULL_CHK  = 12'b000000100000,
        S_SHIFT_RD  = 12'b000001000000,
        S_SHIFT_CHK = 12'b000010000000,
        S_INS_OK    = 12'b000100000000,
        S_READ_WAIT = 12'b001000000000,
        S_FINISH    = 12'b010000000000,
        S_SPARE     = 12'b100000000000
    } t_state;

    typedef enum logic [4:0] {
        TK_SEED1 = 5'b00001,
        TK_SEED2 = 5'b00010,
        TK_RUN   = 5'b00100,
        TK_FINAL = 5'b01000,
        TK_LOOK  = 5'b10000
    } t_task;

    t_state r_state, n_state;
    t_task  r_task, n_task;

    always_comb begin
        n_state = r_state;
        n_task  = r_task;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_st.op)
                    OP_READ: begin
                        if (i_st.sel_ok) begin
                            o_cmd.rd_sel = 1'b1;
                            n_state = S_READ_WAIT;
                        end else begin
                            n_state = S_FINISH;
                        end
                    end
                    OP_LOOK: begin
                        o_cmd.ins_begin = 1'b1;
                        o_cmd.ins_src = SRC_LOOK;
                        n_task = TK_LOOK;
                        n_state = S_SRCH_RD;
                    end
                    OP_PUSH: begin
                        if (i_st.need_ins && i_st.phase == PH_MONO) begin
                            o_cmd.clr_used = 1'b1;
                            o_cmd.ins_begin = 1'b1;
                            o_cmd.ins_src = SRC_FIRST;
                            n_task = TK_SEED1;
                            n_state = S_SRCH_RD;
                        end else if (i_st.need_ins) begin
                            o_cmd.ins_begin = 1'b1;
                            o_cmd.ins_src = SRC_RUN;
                            n_task = TK_RUN;
                            n_state = S_SRCH_RD;
                        end else begin
                            o_cmd.push_upd = 1'b1;
                            n_state = S_POST;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_POST: begin
                if (!i_st.last) begin
                    n_state = S_IDLE;
                end else if (i_st.phase == PH_INDEXED) begin
                    // The open run is added before the rectangle is reported.
                    o_cmd.ins_begin = 1'b1;
                    o_cmd.ins_src = SRC_RUN;
                    n_task = TK_FINAL;
                    n_state = S_SRCH_RD;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SRCH_RD: begin
                if (i_st.k_end) begin
                    n_state = (r_task == TK_LOOK) ? S_FINISH : S_FULL_CHK;
                end else begin
                    o_cmd.srch_rd = 1'b1;
                    n_state = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK: begin
                if (i_st.hit && r_task == TK_LOOK) begin
                    o_cmd.look_hit = 1'b1;
                    n_state = S_FINISH;
                end else if (i_st.hit) begin
                    o_cmd.set_hit = 1'b1;
                    n_state = S_SHIFT_RD;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state = S_SRCH_RD;
                end
            end
            S_FULL_CHK: begin
                if (i_st.full) begin
                    o_cmd.fail = 1'b1;
                    n_state = (r_task == TK_FINAL) ? S_FINISH : S_POST;
                end else begin
                    o_cmd.new_slot = 1'b1;
                    n_state = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                if (i_st.j_zero) begin
                    o_cmd.put = 1'b1;
                    n_state = S_INS_OK;
                end else begin
                    o_cmd.shift_rd = 1'b1;
                    n_state = S_SHIFT_CHK;
                end
            end
            S_SHIFT_CHK: begin
                if (i_st.shift_less) begin
                    o_cmd.shift_move = 1'b1;
                    n_state = S_SHIFT_RD;
                end else begin
                    o_cmd.put = 1'b1;
                    n_state = S_INS_OK;
                end
            end
            S_INS_OK: begin
                case (r_task)
                    TK_SEED1: begin
                        o_cmd.ins_begin = 1'b1;
                        o_cmd.ins_src = SRC_SECOND;
                        n_task = TK_SEED2;
                        n_state = S_SRCH_RD;
                    end
                    TK_SEED2: begin
                        o_cmd.seed_ok = 1'b1;
                        n_state = S_POST;
                    end
                    TK_RUN: begin
                        o_cmd.run_ok = 1'b1;
                        n_state = S_POST;
                    end
                    default: n_state = S_FINISH;
                endcase
            end
            S_READ_WAIT: n_state = S_FINISH;
            S_FINISH: begin
                if (i_st.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_task  <= TK_SEED1;
        end else begin
            r_state <= n_state;
            r_task  <= n_task;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

/* hdl/tpa_dp.sv */
// Rectangle scan registers, sorted palette memory and result register.
module tpa_dp import tpa_pkg::*; #(
    parameter int PALETTE_DEPTH = 256,
    parameter int MAX_PIXELS    = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_st,
    input  logic [USED_W-1:0]  i_max_colors,
    input  logic [1:0]         i_opcode,
    input  logic [COLOR_W-1:0] i_pixel_color,
    input  logic [7:0]         i_entry_select,
    input  logic               i_last,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [1:0]         o_rect_class,
    output logic [USED_W-1:0]  o_color_count,
    output logic [COLOR_W-1:0] o_background,
    output logic [COLOR_W-1:0] o_foreground,
    output logic [COLOR_W-1:0] o_entry_color,
    output logic [CNT_W-1:0]   o_entry_pixels,
    output logic [7:0]         o_entry_index,
    output logic               o_found
);

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_PIXELS);
    localparam logic [USED_W-1:0] DEPTH_N = USED_W'(PALETTE_DEPTH);

    logic [1:0]         r_op, n_op;
    logic [COLOR_W-1:0] r_pix, n_pix;
    logic [7:0]         r_sel, n_sel;
    logic               r_last, n_last;
    t_phase             r_phase, n_phase;
    logic [COLOR_W-1:0] r_first, n_first, r_second, n_second, r_run, n_run;
    logic [CNT_W-1:0]   r_fc, n_fc, r_sc, n_sc, r_rc, n_rc;
    logic [USED_W-1:0]  r_used, n_used, r_k, n_k, r_j, n_j;
    logic [COLOR_W-1:0] r_ins_color, n_ins_color;
    logic [CNT_W-1:0]   r_ins_cnt, n_ins_cnt;
    logic               r_hit, n_hit;

    logic [COLOR_W+CNT_W-1:0] ram_q, ram_wdata;
    logic [COLOR_W-1:0]       q_color;
    logic [CNT_W-1:0]         q_cnt;
    logic [CNT_W:0]           sum;
    logic [USED_W-1:0]        j_prev;
    logic [AW-1:0]            raddr;
    logic                     ram_re, ram_we;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
        return (x < CNT_MAX) ? x + 1'b1 : CNT_MAX;
    endfunction

    assign q_color = ram_q[COLOR_W+CNT_W-1:CNT_W];
    assign q_cnt   = ram_q[CNT_W-1:0];
    assign sum     = {1'b0, q_cnt} + {1'b0, r_ins_cnt};
    assign j_prev  = r_j - 1'b1;

    always_comb begin
        n_op = r_op; n_pix = r_pix; n_sel = r_sel; n_last = r_last;
        n_phase = r_phase;
        n_first = r_first; n_second = r_second; n_run = r_run;
        n_fc = r_fc; n_sc = r_sc; n_rc = r_rc;
        n_used = r_used; n_k = r_k; n_j = r_j;
        n_ins_color = r_ins_color; n_ins_cnt = r_ins_cnt; n_hit = r_hit;
        if (i_cmd.capture) begin
            n_op = i_opcode; n_pix = i_pixel_color;
            n_sel = i_entry_select; n_last = i_last;
        end
        if (i_cmd.push_upd) begin
            case (r_phase)
                PH_SOLID: begin
                    if (r_fc == '0) begin
                        n_used = '0;
                        n_first = r_pix;
                        n_fc = CNT_W'(1);
                    end else if (r_pix == r_first) begin
                        n_fc = sat_inc(r_fc);
                    end else if (i_max_colors < USED_W'(2)) begin
                        n_phase = PH_ABORT;
                    end else begin
                        n_second = r_pix;
                        n_sc = '0;
                        n_phase = PH_MONO;
                    end
                end
                PH_MONO: begin
                    if (r_pix == r_first) begin
                        n_fc = sat_inc(r_fc);
                    end else begin
                        n_sc = sat_inc(r_sc);
                    end
                end
                PH_INDEXED: n_rc = sat_inc(r_rc);
                default: ;
            endcase
        end
        if (i_cmd.clr_used) begin
            n_used = '0;
        end
        if (i_cmd.ins_begin) begin
            n_k = '0;
            n_hit = 1'b0;
            case (i_cmd.ins_src)
                SRC_FIRST: begin n_ins_color = r_first; n_ins_cnt = r_fc; end
                SRC_SECOND: begin n_ins_color = r_second; n_ins_cnt = r_sc; end
                SRC_RUN: begin n_ins_color = r_run; n_ins_cnt = r_rc; end
                default: begin n_ins_color = r_pix; n_ins_cnt = '0; end
            endcase
        end
        if (i_cmd.k_inc) begin
            n_k = r_k + 1'b1;
        end
        if (i_cmd.set_hit) begin
            n_ins_cnt = (sum > {1'b0, CNT_MAX}) ? CNT_MAX : sum[CNT_W-1:0];
            n_j = r_k;
        end
        if (i_cmd.look_hit) begin
            n_hit = 1'b1;
        end
        if (i_cmd.fail) begin
            n_used = '0;
            n_phase = PH_ABORT;
        end
        if (i_cmd.new_slot) begin
            n_j = r_used;
            n_used = r_used + 1'b1;
        end
        if (i_cmd.shift_move) begin
            n_j = j_prev;
        end
        if (i_cmd.seed_ok || i_cmd.run_ok) begin
            n_run = r_pix;
            n_rc = CNT_W'(1);
        end
        if (i_cmd.seed_ok) begin
            n_phase = PH_INDEXED;
        end
        if (i_cmd.load_out && r_op == OP_PUSH) begin
            n_phase = PH_SOLID;
            n_first = '0; n_second = '0; n_run = '0;
            n_fc = '0; n_sc = '0; n_rc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SOLID;
            r_first <= '0; r_second <= '0; r_run <= '0;
            r_fc <= '0; r_sc <= '0; r_rc <= '0;
            r_used <= '0; r_k <= '0; r_j <= '0; r_hit <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_first <= n_first; r_second <= n_second; r_run <= n_run;
            r_fc <= n_fc; r_sc <= n_sc; r_rc <= n_rc;
            r_used <= n_used; r_k <= n_k; r_j <= n_j; r_hit <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_pix <= n_pix; r_sel <= n_sel; r_last <= n_last;
        r_ins_color <= n_ins_color; r_ins_cnt <= n_ins_cnt;
    end

    // One read port serves the search, the shift and the entry read.
    assign ram_re = i_cmd.srch_rd | i_cmd.shift_rd | i_cmd.rd_sel;
    always_comb begin
        if (i_cmd.srch_rd) begin
            raddr = r_k[AW-1:0];
        end else if (i_cmd.shift_rd) begin
            raddr = j_prev[AW-1:0];
        end else begin
            raddr = r_sel[AW-1:0];
        end
    end
    assign ram_we    = i_cmd.shift_move | i_cmd.put;
    assign ram_wdata = i_cmd.shift_move ? ram_q : {r_ins_color, r_ins_cnt};

    tpa_ram #(
        .WIDTH(COLOR_W + CNT_W),
        .DEPTH(PALETTE_DEPTH)
    ) u_pal (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_j[AW-1:0]),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(raddr),
        .o_rdata(ram_q)
    );

    always_comb begin
        o_st.op       = r_op;
        o_st.last     = r_last;
        o_st.phase    = r_phase;
        o_st.need_ins = (r_phase == PH_MONO && r_pix != r_first && r_pix != r_second) ||
                        (r_phase == PH_INDEXED && r_pix != r_run);
        o_st.k_end    = (r_k == r_used);
        o_st.hit      = (q_color == r_ins_color);
        o_st.full     = (r_used >= DEPTH_N) || (r_used >= i_max_colors);
        o_st.j_zero   = (r_j == '0);
        o_st.shift_less = (q_cnt < r_ins_cnt);
        o_st.sel_ok   = ({1'b0, r_sel} < r_used);
        o_st.out_free = !o_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_rect_class   <= CLS_FULL;
            o_color_count  <= '0;
            o_background   <= '0;
            o_foreground   <= '0;
            o_entry_color  <= '0;
            o_entry_pixels <= '0;
            o_entry_index  <= '0;
            o_found        <= 1'b0;
            case (r_op)
                OP_READ: begin
                    if (o_st.sel_ok) begin
                        o_entry_color  <= q_color;
                        o_entry_pixels <= q_cnt;
                        o_found        <= 1'b1;
                    end
                end
                OP_LOOK: begin
                    if (r_hit) begin
                        o_entry_index <= r_k[7:0];
                        o_found       <= 1'b1;
                    end
                end
                default: begin
                    case (r_phase)
                        PH_SOLID: begin
                            o_rect_class  <= CLS_SOLID;
                            o_color_count <= USED_W'(1);
                            o_background  <= r_first;
                        end
                        PH_MONO: begin
                            o_rect_class  <= CLS_MONO;
                            o_color_count <= USED_W'(2);
                            o_background  <= (r_fc > r_sc) ? r_first : r_second;
                            o_foreground  <= (r_fc > r_sc) ? r_second : r_first;
                        end
                        PH_INDEXED: begin
                            o_rect_class  <= CLS_INDEXED;
                            o_color_count <= r_used;
                        end
                        default: ;
                    endcase
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= DEPTH_N)
        else $error("palette fill exceeds its depth");
    a_put_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.put |-> (r_j < r_used))
        else $error("palette write outside the filled part");
    a_mono_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MONO) |-> (r_first != r_second))
        else $error("two-color scan holds equal colors");
`endif

endmodule

/* hdl/tight_palette_analyzer.sv */
// Top level of the palette analyzer: register port, sequencer and datapath.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------
//  in       | input     | i_in_valid / o_in_stall | opcode, pixel, select, last
//  out      | output    | o_out_valid/i_out_stall | class, count, colors, entry
//  config   | APB       | psel/penable/pready     | max_colors at byte address 0
//
// A push without a new run needs no palette search; a new run or the closing pixel
// of an indexed rectangle searches the palette and then moves entries to keep it
// sorted, one entry at a time, since the palette memory has a single read port.
// A lookup searches the palette one entry at a time; an entry read is one access.
// Reset is synchronous and active low; the palette memory is never cleared.
// An item is taken only from idle; a finished result waits in the output
// register while the next item is taken.
module tight_palette_analyzer import tpa_pkg::*; #(
    parameter int PALETTE_DEPTH = 256,
    parameter int MAX_PIXELS    = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic [COLOR_W-1:0] i_pixel_color,
    input  logic [7:0]         i_entry_select,
    input  logic               i_last,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_rect_class,
    output logic [USED_W-1:0]  o_color_count,
    output logic [COLOR_W-1:0] o_background,
    output logic [COLOR_W-1:0] o_foreground,
    output logic [COLOR_W-1:0] o_entry_color,
    output logic [CNT_W-1:0]   o_entry_pixels,
    output logic [7:0]         o_entry_index,
    output logic               o_found,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [USED_W-1:0] r_max_colors;
    t_cmd              cmd;
    t_status           st;

    assign pready = 1'b1;

    // Byte offset bits are ignored; bit two picks the register word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_colors <= USED_W'(256);
        end else if (psel && penable && pwrite && paddr[2] == REG_MAX_COLORS) begin
            r_max_colors <= pwdata[USED_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_MAX_COLORS) ?
                    {{(32 - USED_W){1'b0}}, r_max_colors} : '0;

    tpa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_st      (st),
        .o_cmd     (cmd),
        .o_in_stall(o_in_stall)
    );

    tpa_dp #(
        .PALETTE_DEPTH(PALETTE_DEPTH),
        .MAX_PIXELS   (MAX_PIXELS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_st          (st),
        .i_max_colors  (r_max_colors),
        .i_opcode      (i_opcode),
        .i_pixel_color (i_pixel_color),
        .i_entry_select(i_entry_select),
        .i_last        (i_last),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_rect_class  (o_rect_class),
        .o_color_count (o_color_count),
        .o_background  (o_background),
        .o_foreground  (o_foreground),
        .o_entry_color (o_entry_color),
        .o_entry_pixels(o_entry_pixels),
        .o_entry_index (o_entry_index),
        .o_found       (o_found)
    );

endmodule
